@@ hdl/i2cbe_pkg.sv @@
// Package for the I2C master bit engine: command codes, field widths and item types.
// No dependencies; imported by every module of the engine.
`timescale 1ns / 1ps

package i2cbe_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 5;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [OpW-1:0] OP_NONE  = 3'd0;
  localparam logic [OpW-1:0] OP_START = 3'd1;
  localparam logic [OpW-1:0] OP_STOP  = 3'd2;
  localparam logic [OpW-1:0] OP_WRITE = 3'd3;
  localparam logic [OpW-1:0] OP_READ  = 3'd4;

  localparam logic [PhaseW-1:0] PH_ACK  = 5'd16;
  localparam logic [PhaseW-1:0] PH_LAST = 5'd17;

  localparam logic [ByteW-1:0] MSB_MASK = 8'h80;
  localparam logic [ByteW-1:0] LSB_MASK = 8'h01;

  typedef struct packed {
    logic             sda_in;
    logic             send_nak;
    logic [ByteW-1:0] tx_byte;
    logic [OpW-1:0]   operation;
  } in_item_t;

  typedef struct packed {
    logic             ack_bit;
    logic [ByteW-1:0] rx_byte;
    logic             done_res;
    logic             busy_res;
    logic             sda_out;
    logic             scl;
  } out_item_t;

endpackage

@@ hdl/i2cbe_in_stage.sv @@
// Input register stage of the I2C master bit engine.
// Holds one tick request until the step stage takes it; uses i2cbe_pkg.
`timescale 1ns / 1ps

module i2cbe_in_stage import i2cbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_item_t s_item_i,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output in_item_t m_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign s_ready_o = !valid_q || m_ready_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_item_o  = item_q;

endmodule

@@ hdl/i2cbe_step.sv @@
// Bus sequencer of the I2C master bit engine: state and per-tick line levels.
// Result goes to a registered output with backpressure; uses i2cbe_pkg.
`timescale 1ns / 1ps

module i2cbe_step import i2cbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [OpW-1:0]    cmd_q, cmd_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic [ByteW-1:0]  rx_q, rx_d;
  logic              nak_q, nak_d;
  logic              ack_q, ack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              out_valid_q;
  out_item_t         out_item_q, out_item_d;

  logic              adv, start, last, busy, scl, sda;
  logic [OpW-1:0]    cmd;
  logic [ByteW-1:0]  sh;
  logic [PhaseW-1:0] p;
  logic              nak;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign adv        = in_valid_i && in_ready_o;

  always_comb begin
    start = (cmd_q == OP_NONE) &&
            (in_item_i.operation == OP_START || in_item_i.operation == OP_STOP ||
             in_item_i.operation == OP_WRITE || in_item_i.operation == OP_READ);
    cmd = start ? in_item_i.operation : cmd_q;
    p   = start ? '0 : phase_q;
    sh  = shift_q;
    nak = nak_q;
    if (start && in_item_i.operation == OP_WRITE) begin
      sh = in_item_i.tx_byte;
    end else if (start && in_item_i.operation == OP_READ) begin
      sh  = '0;
      nak = in_item_i.send_nak;
    end

    scl     = scl_q;
    sda     = sda_q;
    busy    = 1'b1;
    last    = 1'b0;
    shift_d = sh;
    rx_d    = rx_q;
    ack_d   = ack_q;

    case (cmd)
      OP_START: begin
        scl  = 1'b1;
        sda  = (p == '0);
        last = (p != '0);
      end
      OP_STOP: begin
        scl  = 1'b1;
        sda  = (p != '0);
        last = (p != '0);
      end
      OP_WRITE: begin
        if (!p[PhaseW-1]) begin
          sda = |(sh & MSB_MASK);
          scl = !p[0];
          if (p[0]) begin
            shift_d = {sh[ByteW-2:0], 1'b0};
          end
        end else if (p == PH_ACK) begin
          scl   = 1'b1;
          sda   = 1'b1;
          ack_d = in_item_i.sda_in;
        end else begin
          scl  = 1'b0;
          sda  = 1'b1;
          last = 1'b1;
        end
      end
      OP_READ: begin
        if (!p[PhaseW-1]) begin
          sda = 1'b1;
          scl = !p[0];
          if (!p[0]) begin
            shift_d = {sh[ByteW-2:0], in_item_i.sda_in & LSB_MASK[0]};
          end
        end else if (p == PH_ACK) begin
          scl = 1'b1;
          sda = nak;
        end else begin
          scl  = 1'b0;
          sda  = nak;
          rx_d = sh;
          last = 1'b1;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase

    nak_d   = nak;
    scl_d   = scl;
    sda_d   = sda;
    cmd_d   = cmd;
    phase_d = p + 1'b1;
    if (!busy) begin
      phase_d = phase_q;
    end else if (last) begin
      cmd_d   = OP_NONE;
      phase_d = '0;
      if (cmd == OP_START) begin
        scl_d = 1'b0;
        sda_d = 1'b0;
      end
    end

    out_item_d.scl      = scl;
    out_item_d.sda_out  = sda;
    out_item_d.busy_res = busy;
    out_item_d.done_res = last;
    out_item_d.rx_byte  = rx_d;
    out_item_d.ack_bit  = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      cmd_q       <= OP_NONE;
      shift_q     <= '0;
      rx_q        <= '0;
      nak_q       <= 1'b0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        shift_q <= shift_d;
        rx_q    <= rx_d;
        nak_q   <= nak_d;
        ack_q   <= ack_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hdl/i2c_master_bit_engine_top.sv @@
// I2C master bit engine: one timing tick in, one line-level result out.
// Instantiates i2cbe_in_stage and i2cbe_step; uses i2cbe_pkg.
//
// Usage:
//   Slave stream (s_axis_*): one request per bus timing tick, carrying the
//   sampled SDA level and, when the engine is idle, a command (start, stop,
//   write byte, read byte). Master stream (m_axis_*): one result per tick with
//   the SCL level and SDA drive for that tick, busy/done flags, the last read
//   byte and the last sampled acknowledge.
//   Path: a request is held in the input register, and its result is then
//   captured in the result register before it is presented on m_axis_*.
//   Throughput: one tick per cycle while m_axis_tready is high; the sequencer
//   step is a single pass of logic between the input and result registers.
//   Commands take two ticks (start, stop) or eighteen ticks (write, read);
//   operation is ignored while a command is running.
//   Reset: engine idle, SCL and SDA released, read byte and acknowledge zero,
//   both pipeline registers empty.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register fills, and s_axis_tready falls; no request is lost or repeated.
`timescale 1ns / 1ps

module i2c_master_bit_engine_top import i2cbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] operation, [10:3] tx_byte, [11] send_nak, [12] sda_in, [15:13] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_bit, [15:13] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  in_item_t  s_item, mid_item;
  out_item_t out_item;
  logic      mid_valid, mid_ready;

  assign s_item.operation = s_axis_tdata[2:0];
  assign s_item.tx_byte   = s_axis_tdata[10:3];
  assign s_item.send_nak  = s_axis_tdata[11];
  assign s_item.sda_in    = s_axis_tdata[12];

  i2cbe_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .m_valid_o (mid_valid),
    .m_ready_i (mid_ready),
    .m_item_o  (mid_item)
  );

  i2cbe_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_item_i   (mid_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {3'b000, out_item.ack_bit, out_item.rx_byte, out_item.done_res,
                         out_item.busy_res, out_item.sda_out, out_item.scl};

endmodule
